/* sv/dtq_pkg.sv */
// Package for the delayed event timer queue.
// Holds the command codes, the stored entry layout and the sequencer state type.
// No dependencies.
`default_nettype none

package dtq_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 16;
  localparam int TIMER_W  = 16;
  localparam int DELAY_W  = 15;
  localparam int AMOUNT_W = 8;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // One queue entry as it sits in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0]            id;
    logic [HANDLE_W-1:0]        handle;
    logic signed [TIMER_W-1:0]  timer;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage

`default_nettype wire

/* sv/dtq_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/delayed_event_timer_queue.sv */
// Top level of the delayed event timer queue.
// Depends on dtq_pkg and dtq_ram.
`default_nettype none

// The block keeps up to QUEUE_DEPTH pending events, each an id, an owner
// handle and a signed countdown, in a single entry memory. An add command
// appends an event at the tail and is dropped without notice when the queue
// is full; a clear command empties the queue. Neither gives a result. A
// tick command subtracts tick_amount from every countdown and emits, in
// queue order, one result transfer for each event that reaches zero or
// below; last_fired marks the final one of the tick. Events that survive
// are written back compacted, keeping their order. A tick walks the entries
// one per cycle through the read port of the entry memory, except while the
// output side holds off a result, and the block takes no new command until
// the walk, and the hand-over of the held result when anything fired, is
// done. The last result of a tick waits in an output register, so the next
// command can be accepted while that result is still on offer.

module delayed_event_timer_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] event_id,
  input  wire logic [15:0] owner_handle,
  input  wire logic [14:0] delay_ticks,
  input  wire logic [7:0]  tick_amount,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      fired_id,
  output logic [15:0]      fired_handle,
  output logic             last_fired
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  dtq_pkg::state_t state;

  // Number of live entries, and the read and write positions of a tick walk.
  logic [CW-1:0] count;
  logic [AW-1:0] src;
  logic [CW-1:0] dst;
  logic [dtq_pkg::AMOUNT_W-1:0] amount;

  // A fired event is held here until it is known whether it is the last.
  logic                          pend_valid;
  logic [dtq_pkg::ID_W-1:0]      pend_id;
  logic [dtq_pkg::HANDLE_W-1:0]  pend_handle;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  dtq_pkg::entry_t      ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  dtq_pkg::entry_t      rd_entry;

  logic                        in_acc;
  logic                        out_free;
  logic signed [dtq_pkg::TIMER_W:0] t_wide;
  logic                        fire;
  logic                        last_src;
  logic                        stall;
  logic                        eval_go;
  logic                        load_mid;
  logic                        load_last;

  dtq_ram #(
    .WIDTH (dtq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign in_ready = (state == dtq_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Stored timers stay within 0..32767, so one extra bit covers the subtraction.
  assign t_wide = $signed({rd_entry.timer[dtq_pkg::TIMER_W-1], rd_entry.timer})
                - $signed({{(dtq_pkg::TIMER_W + 1 - dtq_pkg::AMOUNT_W){1'b0}}, amount});
  assign fire     = t_wide[dtq_pkg::TIMER_W] || (t_wide == '0);
  assign last_src = (CW'(src) + CW'(1)) >= count;

  // A second firing needs the output register free to take the held one.
  assign stall     = (state == dtq_pkg::ST_EVAL) && fire && pend_valid && !out_free;
  assign eval_go   = (state == dtq_pkg::ST_EVAL) && !stall;
  assign load_mid  = eval_go && fire && pend_valid;
  assign load_last = (state == dtq_pkg::ST_FLUSH) && out_free;

  // Survivors are written at dst, which never passes src, so the write of a
  // compacted entry never lands on the entry being read next.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = dst[AW-1:0];
    ram_raddr = src + AW'(1);
    ram_wdata.id     = rd_entry.id;
    ram_wdata.handle = rd_entry.handle;
    ram_wdata.timer  = t_wide[dtq_pkg::TIMER_W-1:0];
    if (state == dtq_pkg::ST_IDLE) begin
      ram_waddr        = count[AW-1:0];
      ram_raddr        = '0;
      ram_wdata.id     = event_id;
      ram_wdata.handle = owner_handle;
      ram_wdata.timer  = dtq_pkg::TIMER_W'(delay_ticks);
      ram_we = in_acc && (cmd == dtq_pkg::CMD_ADD) && (count < DEPTH_C);
      ram_re = in_acc && (cmd == dtq_pkg::CMD_TICK) && (count != '0);
    end else if (eval_go) begin
      ram_we = !fire;
      ram_re = !last_src;
    end
  end

  // Sequencer and queue bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dtq_pkg::ST_IDLE;
      count      <= '0;
      src        <= '0;
      dst        <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        dtq_pkg::ST_IDLE: begin
          if (in_acc) begin
            priority if (cmd == dtq_pkg::CMD_ADD) begin
              if (count < DEPTH_C) begin
                count <= count + CW'(1);
              end
            end else if (cmd == dtq_pkg::CMD_TICK) begin
              src <= '0;
              dst <= '0;
              if (count != '0) begin
                state <= dtq_pkg::ST_EVAL;
              end
            end else if (cmd == dtq_pkg::CMD_CLEAR) begin
              count <= '0;
            end else begin
              count <= count;
            end
          end
        end
        dtq_pkg::ST_EVAL: begin
          if (eval_go) begin
            if (fire) begin
              pend_valid <= 1'b1;
            end else begin
              dst <= dst + CW'(1);
            end
            if (last_src) begin
              count <= fire ? dst : dst + CW'(1);
              state <= (fire || pend_valid) ? dtq_pkg::ST_FLUSH : dtq_pkg::ST_IDLE;
            end else begin
              src <= src + AW'(1);
            end
          end
        end
        dtq_pkg::ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= dtq_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= dtq_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Held firing and the tick amount need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      amount <= tick_amount;
    end
    if (eval_go && fire) begin
      pend_id     <= rd_entry.id;
      pend_handle <= rd_entry.handle;
    end
  end

  // Output register: a held firing moves out with last_fired clear when a
  // later one fires, and with it set once the walk is over.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_mid || load_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid || load_last) begin
      fired_id     <= pend_id;
      fired_handle <= pend_handle;
      last_fired   <= load_last;
    end
  end

endmodule

`default_nettype wire

/* sv/dtq_checker.sv */
// Port-level checker for the delayed event timer queue, bound to the top level.
// Depends on dtq_pkg for the command codes.
`default_nettype none

module dtq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] fired_id,
  input wire logic [15:0] fired_handle,
  input wire logic        last_fired
);

  // A result on offer stays put until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fired_id)
      && $stable(fired_handle) && $stable(last_fired))
    else $error("result changed while stalled");

  // Nothing comes out right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A command other than tick never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd != dtq_pkg::CMD_TICK) && !out_valid |=> !out_valid)
    else $error("result from a non-tick command");

  // A tick right after a clear finds the queue empty and leaves the block ready.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (cmd == dtq_pkg::CMD_CLEAR))
      ##1 (in_valid && in_ready && (cmd == dtq_pkg::CMD_TICK)) |=> in_ready)
    else $error("tick on empty queue kept the block busy");

endmodule

bind delayed_event_timer_queue dtq_checker u_dtq_checker (.*);

`default_nettype wire
